>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

>>> hw/rtl/exwt_pkg.sv
// Widths, constants and log table functions of the exponential wait generator.
package exwt_pkg;

   localparam int WORD_W   = 32;
   localparam int POS_W    = 5;
   localparam int LOG_FRAC = 28;
   localparam int ENTRY_W  = LOG_FRAC + 1;
   localparam int LOG_W    = 34;
   localparam int DIFF_W   = 33;
   localparam int SCALE_W  = 16;
   localparam int T_W      = DIFF_W + SCALE_W;
   localparam int TH_W     = T_W - 32;
   localparam int PH_W     = TH_W + 32;
   localparam int SUM_W    = PH_W + 1;
   localparam int WAIT_W   = 21;

   localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd10000;
   localparam logic [31:0]        LN2_Q32     = 32'd2977044472;
   localparam logic [WAIT_W-1:0]  WAIT_MAX    = '1;

   // log2 of a Q1.30 mantissa in [1,2), bit-serial squaring, result Q0.28
   function automatic logic [ENTRY_W-1:0] mant_log2(logic [31:0] y_in);
      logic [63:0]         y;
      logic [ENTRY_W-1:0]  res;
      y   = 64'(y_in);
      res = '0;
      for (int k = 1; k <= LOG_FRAC; k++) begin
         y = (y * y) >> 30;
         if (y >= 64'h8000_0000) begin
            y = y >> 1;
            res[LOG_FRAC-k] = 1'b1;
         end
      end
      return res;
   endfunction

   // entry i of the table log2(1 + i/2^table_bits); the last entry is 1.0
   function automatic logic [ENTRY_W-1:0] rom_entry(int table_bits, int i);
      logic [31:0] y;
      y = 32'((1 << table_bits) + i) << (30 - table_bits);
      if (i == (1 << table_bits))
         return ENTRY_W'(1) << LOG_FRAC;
      return mant_log2(y);
   endfunction

   // interpolated log2 of the all-ones word, Q6.28
   function automatic logic [LOG_W-1:0] max_log2(int table_bits);
      logic [63:0] lo;
      logic [63:0] hi;
      logic [63:0] rem;
      int          rw;
      rw  = 31 - table_bits;
      lo  = 64'(rom_entry(table_bits, (1 << table_bits) - 1));
      hi  = 64'(1) << LOG_FRAC;
      rem = (64'(1) << rw) - 64'(1);
      return LOG_W'((64'(31) << LOG_FRAC) + lo + (((hi - lo) * rem) >> rw));
   endfunction

endpackage

>>> hw/rtl/exwt_req_if.sv
// Request channel: one random word per transfer.
interface exwt_req_if;
   import exwt_pkg::*;

   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] random_word;

   modport source (output valid, output random_word, input ready);
   modport sink   (input valid, input random_word, output ready);
endinterface

>>> hw/rtl/exwt_rsp_if.sv
// Response channel: one wait time per transfer.
interface exwt_rsp_if;
   import exwt_pkg::*;

   logic              valid;
   logic              ready;
   logic [WAIT_W-1:0] wait_ms;

   modport source (output valid, output wait_ms, input ready);
   modport sink   (input valid, input wait_ms, output ready);
endinterface

>>> hw/rtl/exwt_log2.sv
// Six-stage pipelined negative log: log2(all ones) - log2(~word), result Q5.28.
`include "assert_macros.svh"

module exwt_log2 #(
   parameter int LOG_TABLE_BITS = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  logic [exwt_pkg::WORD_W-1:0] in_word,
   output logic                        out_valid,
   input  logic                        out_ready,
   output logic [exwt_pkg::DIFF_W-1:0] out_neg_log
);
   import exwt_pkg::*;

   localparam int RW = 31 - LOG_TABLE_BITS;
   localparam int TS = (1 << LOG_TABLE_BITS) + 1;
   localparam int NS = 6;

   typedef logic [TS-1:0][ENTRY_W-1:0] rom_type;

   function automatic rom_type build_rom();
      rom_type r;
      for (int i = 0; i < TS; i++)
         r[i] = rom_entry(LOG_TABLE_BITS, i);
      return r;
   endfunction

   localparam rom_type             LOG_ROM  = build_rom();
   localparam logic [LOG_W-1:0]    LOG_MAX  = max_log2(LOG_TABLE_BITS);
   localparam logic [DIFF_W-1:0]   DIFF_MAX = DIFF_W'(LOG_MAX);
   localparam logic [ENTRY_W-1:0]  ROM_ONE  = ENTRY_W'(1) << LOG_FRAC;

   logic [NS-1:0] vld_ff;
   logic [NS-1:0] vld_in;
   logic [NS-1:0] en;

   logic [WORD_W-1:0]         v_in;
   logic [POS_W-1:0]          lead_pos;
   logic [WORD_W-1:0]         s1_v_ff;
   logic [POS_W-1:0]          s1_pos_ff;

   logic [WORD_W-1:0]         norm;
   logic [POS_W-1:0]          s2_pos_ff;
   logic [LOG_TABLE_BITS-1:0] s2_idx_ff;
   logic [RW-1:0]             s2_rem_ff;

   logic [LOG_TABLE_BITS:0]   idx_lo;
   logic [LOG_TABLE_BITS:0]   idx_hi;
   logic [ENTRY_W-1:0]        rom_lo;
   logic [ENTRY_W-1:0]        rom_hi;
   logic [POS_W-1:0]          s3_pos_ff;
   logic [ENTRY_W-1:0]        s3_lo_ff;
   logic [ENTRY_W-1:0]        s3_diff_ff;
   logic [RW-1:0]             s3_rem_ff;

   logic [LOG_W-1:0]          s4_base_ff;
   logic [ENTRY_W+RW-1:0]     s4_prod_ff;

   logic [LOG_W-1:0]          s5_lv_ff;

   logic [DIFF_W-1:0]         s6_d_ff;

   // stage enables: a stage moves when it is empty or the next one moves
   always_comb begin
      en[NS-1] = !vld_ff[NS-1] || out_ready;
      for (int k = NS - 2; k >= 0; k--)
         en[k] = !vld_ff[k] || en[k+1];
      vld_in[0] = en[0] ? in_valid : vld_ff[0];
      for (int k = 1; k < NS; k++)
         vld_in[k] = en[k] ? vld_ff[k-1] : vld_ff[k];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // leading one of v = all ones - word
   always_comb begin
      v_in     = ~in_word;
      lead_pos = '0;
      for (int i = 0; i < WORD_W; i++)
         if (v_in[i]) lead_pos = POS_W'(i);
   end

   assign norm   = s1_v_ff << (POS_W'(WORD_W - 1) - s1_pos_ff);
   assign idx_lo = {1'b0, s2_idx_ff};
   assign idx_hi = idx_lo + 1'b1;
   assign rom_lo = LOG_ROM[idx_lo];
   assign rom_hi = LOG_ROM[idx_hi];

   always_ff @(posedge clock) begin
      if (en[0]) begin
         s1_v_ff   <= v_in;
         s1_pos_ff <= lead_pos;
      end
      if (en[1]) begin
         s2_pos_ff <= s1_pos_ff;
         s2_idx_ff <= norm[WORD_W-2 -: LOG_TABLE_BITS];
         s2_rem_ff <= norm[RW-1:0];
      end
      if (en[2]) begin
         s3_pos_ff  <= s2_pos_ff;
         s3_lo_ff   <= rom_lo;
         s3_diff_ff <= rom_hi - rom_lo;
         s3_rem_ff  <= s2_rem_ff;
      end
      if (en[3]) begin
         s4_base_ff <= LOG_W'({s3_pos_ff, LOG_FRAC'(0)}) + LOG_W'(s3_lo_ff);
         s4_prod_ff <= s3_diff_ff * s3_rem_ff;
      end
      if (en[4]) begin
         s5_lv_ff <= s4_base_ff + LOG_W'(s4_prod_ff[ENTRY_W+RW-1:RW]);
      end
      if (en[5]) begin
         s6_d_ff <= (s5_lv_ff < LOG_MAX) ? DIFF_W'(LOG_MAX - s5_lv_ff) : '0;
      end
   end

   assign in_ready    = en[0];
   assign out_valid   = vld_ff[NS-1];
   assign out_neg_log = s6_d_ff;

   `ASSERT_NEXT(a_accept_enters, clock, reset, in_valid && in_ready, vld_ff[0], "accepted word lost at log input")
   `ASSERT_IMPLY(a_slope_bound, clock, reset, vld_ff[2], s3_diff_ff <= ROM_ONE, "log table slope out of range")
   `ASSERT_IMPLY(a_log_bound, clock, reset, vld_ff[NS-1], s6_d_ff <= DIFF_MAX, "negative log above its maximum")

endmodule

>>> hw/rtl/exponential_wait_time_generator_core.sv
// Exponential wait time generator: maps one uniform 32-bit random word to
// floor(-ln(1 - u/(2^32-1)) * scale) ms, saturated at 21 bits. A word is taken
// every cycle when the response side keeps up. Six stages form the fixed-point
// log (leading-one search, normalise, table read of 2^LOG_TABLE_BITS+1 entries,
// interpolation product, sum, difference), then one stage multiplies by the
// scale register, one by ln 2, and the output register sums and saturates. Each
// stage holds its word while the next is full, so stalls lose nothing. The
// all-ones word is accepted and yields no result. The scale register resets
// to 10000.
`include "assert_macros.svh"

module exponential_wait_time_generator_core #(
   parameter int LOG_TABLE_BITS = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   exwt_req_if.sink                     req_bus,
   exwt_rsp_if.source                   rsp_bus,
   input  logic                         csr_write_enable,
   input  logic [exwt_pkg::SCALE_W-1:0] csr_write_data
);
   import exwt_pkg::*;

   logic [SCALE_W-1:0] scale_ff;

   logic               lg_in_valid;
   logic               lg_valid;
   logic               lg_ready;
   logic [DIFF_W-1:0]  lg_d;

   logic               t_vld_ff;
   logic [T_W-1:0]     t_ff;
   logic               p_vld_ff;
   logic [PH_W-1:0]    ph_ff;
   logic [31:0]        pl_hi_ff;
   logic               rsp_valid_ff;
   logic [WAIT_W-1:0]  wait_ff;

   logic               en_t;
   logic               en_p;
   logic               en_out;

   logic [PH_W-1:0]    ph_full;
   logic [63:0]        pl_full;
   logic [SUM_W-1:0]   sum;
   logic [SUM_W-LOG_FRAC-1:0] w_full;
   logic [WAIT_W-1:0]  w_sat;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= SCALE_RESET;
      end else if (csr_write_enable) begin
         scale_ff <= csr_write_data;
      end
   end

   // all-ones word is taken but dropped
   assign lg_in_valid   = req_bus.valid && (req_bus.random_word != '1);
   assign req_bus.ready = lg_ready;

   exwt_log2 #(
      .LOG_TABLE_BITS (LOG_TABLE_BITS)
   ) u_log2 (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (lg_in_valid),
      .in_ready    (lg_ready),
      .in_word     (req_bus.random_word),
      .out_valid   (lg_valid),
      .out_ready   (en_t),
      .out_neg_log (lg_d)
   );

   assign en_out = !rsp_valid_ff || rsp_bus.ready;
   assign en_p   = !p_vld_ff || en_out;
   assign en_t   = !t_vld_ff || en_p;

   always_comb begin
      ph_full = t_ff[T_W-1:32] * LN2_Q32;
      pl_full = t_ff[31:0] * LN2_Q32;
      sum     = SUM_W'(ph_ff) + SUM_W'(pl_hi_ff);
      w_full  = sum[SUM_W-1:LOG_FRAC];
      w_sat   = (w_full > (SUM_W-LOG_FRAC)'(WAIT_MAX)) ? WAIT_MAX : w_full[WAIT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t_vld_ff     <= 1'b0;
         p_vld_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (en_t) t_vld_ff <= lg_valid;
         if (en_p) p_vld_ff <= t_vld_ff;
         if (en_out) rsp_valid_ff <= p_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en_t) begin
         t_ff <= lg_d * scale_ff;
      end
      if (en_p) begin
         ph_ff    <= ph_full;
         pl_hi_ff <= pl_full[63:32];
      end
      if (en_out) begin
         wait_ff <= w_sat;
      end
   end

   assign rsp_bus.valid   = rsp_valid_ff;
   assign rsp_bus.wait_ms = wait_ff;

   `ASSERT_NEXT(a_t_hold, clock, reset, t_vld_ff && !en_p, t_vld_ff && $stable(t_ff), "scaled word changed under stall")
   `ASSERT_NEXT(a_zero_log, clock, reset, lg_valid && en_t && (lg_d == 0), t_ff == 0, "zero log gave non-zero product")
   `ASSERT_NEXT(a_deliver, clock, reset, p_vld_ff && en_out, rsp_valid_ff, "product word not moved to output")

endmodule
